// ===== rtl/trq_pkg.sv =====
// Shared types and constants for the timestamp reorder queue.
`timescale 1ns / 1ps

package trq_pkg;

  localparam int TS_BITS       = 33;
  localparam int FILL_BITS     = 7;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [FILL_BITS-1:0] FILL_RESET = 7'd50;

  // Register index taken from paddr[2].
  localparam logic REG_FILL_LEVEL = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_WRITE,
    ST_SCAN,
    ST_LINK_PREV,
    ST_CHECK,
    ST_POP_RD,
    ST_POP,
    ST_OVERFLOW
  } trq_state_t;

  typedef struct packed {
    logic ent_we;
    logic link_we;
    logic rd_en;
  } trq_store_ctl_t;

endpackage

// ===== rtl/trq_store.sv =====
// Entry and link memories with one write port each and a shared read address with registered read data.
`timescale 1ns / 1ps

module trq_store #(
  parameter int DEPTH = 64,
  parameter int EW    = 52,
  parameter int AW    = 6
) (
  input  logic                    clk,
  input  trq_pkg::trq_store_ctl_t ctl,
  input  logic [AW-1:0]           rd_addr,
  input  logic [AW-1:0]           ent_waddr,
  input  logic [EW-1:0]           ent_wdata,
  input  logic [AW-1:0]           link_waddr,
  input  logic [AW-1:0]           link_wdata,
  output logic [EW-1:0]           ent_rdata,
  output logic [AW-1:0]           link_rdata
);
  import trq_pkg::*;

  logic [EW-1:0] ent_mem  [DEPTH];
  logic [AW-1:0] link_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ctl.rd_en) begin
      ent_rdata <= ent_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (ctl.rd_en) begin
      link_rdata <= link_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/timestamp_reorder_queue_top.sv =====
// Top level of the timestamp reorder queue: sequencer, list pointers and host ports.
`timescale 1ns / 1ps

// The queue holds up to DEPTH packets as a linked list in two memories and walks that
// list with one comparator to find where a new packet goes: before the first entry of
// another stream whose timestamp is not below the packet's own, or else at the tail.
// Once the entry count reaches fill_level, every arrival releases the head entry, and
// a drain beat releases one head entry until the queue is empty. An arrival into a full
// queue is dropped and answered with one result beat that has out_overflow set. An arrival
// takes a free slot, writes its entry, walks the list and checks the fill level, and then
// reads and releases the head if it must; a drain beat reads and releases the head. The
// walk is bound by the single read port of the list memories, which yields one entry per
// cycle. The input is not ready while an item is in progress, but a finished result sits
// in an output register so the next item can be taken before that result is consumed.
// Freed slots are recycled through a free list kept in the link memory, so no clearing
// pass is needed after reset. fill_level is register 0 of the configuration port and
// resets to 50; write it only while the queue is idle.

module timestamp_reorder_queue_top #(
  parameter int DEPTH       = 64,
  parameter int STREAM_BITS = 3,
  parameter int HANDLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [STREAM_BITS-1:0]            in_stream_id,
  input  logic [trq_pkg::TS_BITS-1:0]       in_timestamp,
  input  logic [HANDLE_BITS-1:0]            in_handle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [STREAM_BITS-1:0]            out_stream_id,
  output logic [trq_pkg::TS_BITS-1:0]       out_timestamp,
  output logic [HANDLE_BITS-1:0]            out_handle,
  output logic                              out_overflow,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [trq_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [trq_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [trq_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                              cfg_pready
);
  import trq_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int EW   = STREAM_BITS + TS_BITS + HANDLE_BITS;
  localparam int CMPW = (CW > FILL_BITS) ? CW : FILL_BITS;

  // Sequencer and list state.
  trq_state_t     state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  fresh_r, fresh_nxt;
  logic [AW-1:0]  free_head_r, free_head_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic [AW-1:0]  tail_r, tail_nxt;
  logic [AW-1:0]  cur_r, cur_nxt;
  logic [AW-1:0]  prev_r, prev_nxt;
  logic [AW-1:0]  slot_r, slot_nxt;
  logic           have_prev_r, have_prev_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [FILL_BITS-1:0] fill_r;

  // Latched packet fields.
  logic [STREAM_BITS-1:0] sid_r;
  logic [TS_BITS-1:0]     ts_r;
  logic [HANDLE_BITS-1:0] hnd_r;
  logic                   in_take;

  // Output register.
  logic                   out_valid_r;
  logic                   out_load;
  logic                   out_load_ovf;
  logic [STREAM_BITS-1:0] out_sid_r;
  logic [TS_BITS-1:0]     out_ts_r;
  logic [HANDLE_BITS-1:0] out_hnd_r;
  logic                   out_ovf_r;
  logic                   out_free;

  // Store interface.
  trq_store_ctl_t   st_ctl;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    link_waddr;
  logic [AW-1:0]    link_wdata;
  logic [EW-1:0]    ent_rdata;
  logic [AW-1:0]    link_rdata;

  logic [STREAM_BITS-1:0] e_sid;
  logic [TS_BITS-1:0]     e_ts;
  logic [HANDLE_BITS-1:0] e_hnd;
  logic                   keep_going;
  logic [CW-1:0]          n_inc;
  logic                   cfg_wr;

  assign e_sid = ent_rdata[EW-1 -: STREAM_BITS];
  assign e_ts  = ent_rdata[HANDLE_BITS +: TS_BITS];
  assign e_hnd = ent_rdata[HANDLE_BITS-1:0];

  // The shared comparator: the walk continues past entries of the same stream and past
  // entries that are strictly older than the new packet.
  assign keep_going = (e_sid == sid_r) || (e_ts < ts_r);
  assign n_inc      = n_r + CW'(1);

  assign out_free = !out_valid_r || out_ready;

  trq_store #(
    .DEPTH (DEPTH),
    .EW    (EW),
    .AW    (AW)
  ) u_store (
    .clk        (clk),
    .ctl        (st_ctl),
    .rd_addr    (rd_addr),
    .ent_waddr  (slot_r),
    .ent_wdata  ({sid_r, ts_r, hnd_r}),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .ent_rdata  (ent_rdata),
    .link_rdata (link_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fresh_nxt     = fresh_r;
    free_head_nxt = free_head_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    slot_nxt      = slot_r;
    have_prev_nxt = have_prev_r;
    n_nxt         = n_r;
    st_ctl        = '0;
    rd_addr       = head_r;
    link_waddr    = slot_r;
    link_wdata    = cur_r;
    in_ready      = 1'b0;
    in_take       = 1'b0;
    out_load      = 1'b0;
    out_load_ovf  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind) begin
            if (cnt_r != '0) begin
              state_nxt = ST_POP_RD;
            end
          end else if (cnt_r == CW'(DEPTH)) begin
            state_nxt = ST_OVERFLOW;
          end else begin
            in_take = 1'b1;
            if (cnt_r < fresh_r) begin
              // Take a recycled slot and fetch the next free-list link.
              slot_nxt     = free_head_r;
              rd_addr      = free_head_r;
              st_ctl.rd_en = 1'b1;
              state_nxt    = ST_ALLOC;
            end else begin
              slot_nxt  = fresh_r[AW-1:0];
              fresh_nxt = fresh_r + CW'(1);
              state_nxt = ST_WRITE;
            end
          end
        end
      end

      ST_ALLOC: begin
        free_head_nxt = link_rdata;
        state_nxt     = ST_WRITE;
      end

      ST_WRITE: begin
        st_ctl.ent_we = 1'b1;
        if (cnt_r == '0) begin
          head_nxt  = slot_r;
          tail_nxt  = slot_r;
          cnt_nxt   = CW'(1);
          state_nxt = ST_CHECK;
        end else begin
          rd_addr       = head_r;
          st_ctl.rd_en  = 1'b1;
          cur_nxt       = head_r;
          n_nxt         = '0;
          have_prev_nxt = 1'b0;
          state_nxt     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (keep_going) begin
          prev_nxt      = cur_r;
          have_prev_nxt = 1'b1;
          n_nxt         = n_inc;
          if (n_inc == cnt_r) begin
            // Walked the whole list: append at the tail.
            st_ctl.link_we = 1'b1;
            link_waddr     = tail_r;
            link_wdata     = slot_r;
            tail_nxt       = slot_r;
            cnt_nxt        = cnt_r + CW'(1);
            state_nxt      = ST_CHECK;
          end else begin
            rd_addr      = link_rdata;
            st_ctl.rd_en = 1'b1;
            cur_nxt      = link_rdata;
          end
        end else begin
          st_ctl.link_we = 1'b1;
          link_waddr     = slot_r;
          link_wdata     = cur_r;
          if (have_prev_r) begin
            state_nxt = ST_LINK_PREV;
          end else begin
            head_nxt  = slot_r;
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = ST_CHECK;
          end
        end
      end

      ST_LINK_PREV: begin
        st_ctl.link_we = 1'b1;
        link_waddr     = prev_r;
        link_wdata     = slot_r;
        cnt_nxt        = cnt_r + CW'(1);
        state_nxt      = ST_CHECK;
      end

      ST_CHECK: begin
        if (CMPW'(cnt_r) >= CMPW'(fill_r)) begin
          state_nxt = ST_POP_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_POP_RD: begin
        rd_addr      = head_r;
        st_ctl.rd_en = 1'b1;
        state_nxt    = ST_POP;
      end

      ST_POP: begin
        if (out_free) begin
          out_load       = 1'b1;
          // The released slot goes on top of the free list.
          st_ctl.link_we = 1'b1;
          link_waddr     = head_r;
          link_wdata     = free_head_r;
          free_head_nxt  = head_r;
          cnt_nxt        = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            head_nxt = link_rdata;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_OVERFLOW: begin
        if (out_free) begin
          out_load_ovf = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fresh_r     <= '0;
      free_head_r <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cur_r       <= '0;
      prev_r      <= '0;
      slot_r      <= '0;
      have_prev_r <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fresh_r     <= fresh_nxt;
      free_head_r <= free_head_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      slot_r      <= slot_nxt;
      have_prev_r <= have_prev_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_load || out_load_ovf || (out_valid_r && !out_ready);
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      sid_r <= in_stream_id;
      ts_r  <= in_timestamp;
      hnd_r <= in_handle;
    end
    if (out_load) begin
      out_sid_r <= e_sid;
      out_ts_r  <= e_ts;
      out_hnd_r <= e_hnd;
      out_ovf_r <= 1'b0;
    end else if (out_load_ovf) begin
      out_sid_r <= '0;
      out_ts_r  <= '0;
      out_hnd_r <= '0;
      out_ovf_r <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_stream_id = out_sid_r;
  assign out_timestamp = out_ts_r;
  assign out_handle    = out_hnd_r;
  assign out_overflow  = out_ovf_r;

  // Configuration port: the register index is the word address, paddr[2].
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == REG_FILL_LEVEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= FILL_RESET;
    end else if (cfg_wr) begin
      fill_r <= cfg_pwdata[FILL_BITS-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_FILL_LEVEL) begin
      cfg_prdata = CFG_DATA_BITS'(fill_r);
    end
  end

endmodule

// ===== tb/tb_timestamp_reorder_queue_top.sv =====
// Self-checking testbench for the timestamp reorder queue top level.
`timescale 1ns / 1ps

// The bench drives packet and drain beats into the queue through a valid/ready driver that
// pulls from a pending list, and checks every result beat against its own model of the
// queue. The model keeps the stored packets as a plain list in release order. An arrival
// goes in front of the first held packet of another stream whose timestamp is not below
// its own, or else at the end. Once the count reaches the fill level, the head is
// released. Since only the order of the packets is visible from outside, slot numbers
// and link words are not modeled.
//
// The run is split into phases. Each phase sets the fill level while the queue is idle,
// queues its traffic and then waits until every expected release has come out. The
// extremes of the fill level are covered: one, the full depth, zero (every arrival
// releases at once) and a value above the depth (the queue fills up and overflows).
module tb_timestamp_reorder_queue_top;

  import trq_pkg::*;

  localparam int DEPTH       = 64;
  localparam int STREAM_BITS = 3;
  localparam int HANDLE_BITS = 16;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_DRAIN  = 1'b1;

  // Register index one decodes to nothing, so writes to it must be ignored.
  localparam logic REG_UNUSED = 1'b1;

  localparam logic [TS_BITS-1:0] TS_MAX = {TS_BITS{1'b1}};

  // An arrival walks at most DEPTH entries and then may release the head, so this many
  // quiet cycles cover any beat that is still in flight without producing a result.
  localparam int SETTLE_CYCLES = DEPTH + 40;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct packed {
    logic                   kind;
    logic [STREAM_BITS-1:0] sid;
    logic [TS_BITS-1:0]     ts;
    logic [HANDLE_BITS-1:0] hnd;
  } pkt_beat_t;

  typedef struct packed {
    logic [STREAM_BITS-1:0] sid;
    logic [TS_BITS-1:0]     ts;
    logic [HANDLE_BITS-1:0] hnd;
    logic                   overflow;
  } release_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_kind = KIND_PACKET;
  logic [STREAM_BITS-1:0]       in_stream_id = '0;
  logic [TS_BITS-1:0]           in_timestamp = '0;
  logic [HANDLE_BITS-1:0]       in_handle = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [STREAM_BITS-1:0]       out_stream_id;
  logic [TS_BITS-1:0]           out_timestamp;
  logic [HANDLE_BITS-1:0]       out_handle;
  logic                         out_overflow;
  logic                         cfg_psel = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0]     cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0]     cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0]     cfg_prdata;
  logic                         cfg_pready;

  // Beats waiting to be offered, packets held by the model queue in release order, and
  // the release beats the queue still owes us.
  pkt_beat_t pending_q[$];
  release_t  held_q[$];
  release_t  release_q[$];

  logic [FILL_BITS-1:0] fill_shadow = FILL_RESET;
  int                   err_count = 0;
  int unsigned          cycle_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;

  // The stimulus asks for a long receiver stall by bumping hold_req; the receiver
  // process counts the stall itself.
  int                   hold_req = 0;
  int                   hold_seen = 0;
  int                   hold_left = 0;

  timestamp_reorder_queue_top #(
    .DEPTH      (DEPTH),
    .STREAM_BITS(STREAM_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_stream_id (in_stream_id),
    .in_timestamp (in_timestamp),
    .in_handle    (in_handle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_stream_id(out_stream_id),
    .out_timestamp(out_timestamp),
    .out_handle   (out_handle),
    .out_overflow (out_overflow),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one accepted beat to the model queue and records the release it causes.
  function automatic void reorder_step(input pkt_beat_t b);
    int       pos;
    release_t e;
    if (b.kind == KIND_DRAIN) begin
      if (held_q.size() != 0) begin
        release_q.push_back(held_q.pop_front());
      end
      return;
    end
    // A full queue drops the arrival and answers with an overflow beat of zero fields.
    if (held_q.size() >= DEPTH) begin
      release_q.push_back('{sid: '0, ts: '0, hnd: '0, overflow: 1'b1});
      return;
    end
    e = '{sid: b.sid, ts: b.ts, hnd: b.hnd, overflow: 1'b0};
    pos = held_q.size();
    for (int i = 0; i < held_q.size(); i++) begin
      if (held_q[i].sid != b.sid && held_q[i].ts >= b.ts) begin
        pos = i;
        break;
      end
    end
    held_q.insert(pos, e);
    if (held_q.size() >= int'(fill_shadow)) begin
      release_q.push_back(held_q.pop_front());
    end
  endfunction

  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, fname, want, got);
      err_count++;
    end
  endfunction

  function automatic void add_beat(input logic kind, input logic [STREAM_BITS-1:0] sid,
                                   input logic [TS_BITS-1:0] ts,
                                   input logic [HANDLE_BITS-1:0] hnd);
    pending_q.push_back('{kind: kind, sid: sid, ts: ts, hnd: hnd});
  endfunction

  // Mostly random over all 33 bits, with the two extremes mixed in.
  function automatic logic [TS_BITS-1:0] random_ts();
    int roll;
    roll = $urandom_range(15);
    if (roll == 0) return '0;
    if (roll == 1) return TS_MAX;
    return {1'($urandom_range(1)), 32'($urandom)};
  endfunction

  // Driver: offers the next pending beat, holds it until accepted, and feeds every
  // accepted beat to the model at the edge where it is taken.
  always @(posedge clk) begin : drive_proc
    pkt_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        reorder_step('{kind: in_kind, sid: in_stream_id, ts: in_timestamp, hnd: in_handle});
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          in_valid     <= 1'b1;
          in_kind      <= nxt.kind;
          in_stream_id <= nxt.sid;
          in_timestamp <= nxt.ts;
          in_handle    <= nxt.hnd;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result beat with the oldest expected release and drives the
  // receiver's ready, including the long stall asked for by the stimulus.
  always @(posedge clk) begin : recv_proc
    release_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (release_q.size() == 0) begin
          $display("%0t: unexpected result beat: stream %0d ts 0x%0h handle 0x%0h ovf %0b",
                   $time, out_stream_id, out_timestamp, out_handle, out_overflow);
          err_count++;
        end else begin
          want = release_q.pop_front();
          check_field("out_stream_id", 64'(want.sid), 64'(out_stream_id));
          check_field("out_timestamp", 64'(want.ts), 64'(out_timestamp));
          check_field("out_handle", 64'(want.hnd), 64'(out_handle));
          check_field("out_overflow", 64'(want.overflow), 64'(out_overflow));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("** timestamp_reorder_queue_top: FAILED **");
      $finish;
    end
  end

  // One register access: a setup phase, then an access phase that ends at the edge where
  // pready is seen high. The read data is taken at that edge.
  task automatic cfg_access(input logic wr, input logic idx, input logic [31:0] wdata,
                            output logic [CFG_DATA_BITS-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_fill(input int value);
    logic [CFG_DATA_BITS-1:0] unused_rd;
    cfg_access(1'b1, REG_FILL_LEVEL, 32'(value), unused_rd);
    fill_shadow = FILL_BITS'(value);
  endtask

  task automatic check_fill_readback();
    logic [CFG_DATA_BITS-1:0] rd;
    cfg_access(1'b0, REG_FILL_LEVEL, '0, rd);
    if (rd[FILL_BITS-1:0] !== fill_shadow) begin
      $display("%0t: fill_level readback mismatch: expected %0d, got %0d",
               $time, fill_shadow, rd[FILL_BITS-1:0]);
      err_count++;
    end
  endtask

  // Waits until every queued beat is taken and every expected release has come out, then
  // gives an arrival that releases nothing time to finish its list walk.
  task automatic wait_quiet();
    while (pending_q.size() != 0 || in_valid || release_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Well-formed traffic: one to three streams, each with a rising timestamp and a little
  // backward jitter, so arrivals land anywhere in the list. A share of fully random
  // packets and stray drain beats stands for noise. The queue never holds more packets
  // than the fill level, the depth or the packets sent, so that many
  // drains at the end of the phase empty it, and two more hit it while empty.
  task automatic queue_traffic(input int n_pkts, input int fill);
    logic [TS_BITS-1:0]     lane_ts [3];
    logic [STREAM_BITS-1:0] first_sid;
    int                     lanes;
    int                     lane;
    int                     roll;
    int                     n;
    int                     n_drain;
    first_sid = STREAM_BITS'($urandom);
    lanes = $urandom_range(1, 3);
    for (int k = 0; k < 3; k++) begin
      lane_ts[k] = ($urandom_range(7) == 0) ? TS_MAX - TS_BITS'($urandom_range(20000))
                                            : random_ts();
    end
    n = 0;
    while (n < n_pkts) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        add_beat(KIND_DRAIN, STREAM_BITS'($urandom), random_ts(), HANDLE_BITS'($urandom));
      end else begin
        if (roll < 16) begin
          add_beat(KIND_PACKET, STREAM_BITS'($urandom), random_ts(), HANDLE_BITS'($urandom));
        end else begin
          lane = $urandom_range(lanes - 1);
          lane_ts[lane] += TS_BITS'($urandom_range(3003));
          add_beat(KIND_PACKET, first_sid + STREAM_BITS'(lane),
                   lane_ts[lane] - TS_BITS'($urandom_range(300)), HANDLE_BITS'($urandom));
        end
        n++;
      end
    end
    n_drain = (n_pkts < DEPTH) ? n_pkts : DEPTH;
    if (fill < n_drain) n_drain = fill;
    repeat (n_drain + 2) begin
      add_beat(KIND_DRAIN, STREAM_BITS'($urandom), random_ts(), HANDLE_BITS'($urandom));
    end
  endtask

  task automatic run_phase(input int fill, input int n_pkts, input bit squeeze);
    set_fill(fill);
    check_fill_readback();
    // The long receiver stall starts with the phase, so the output register fills and
    // the queue has to stop taking beats while the driver keeps offering.
    if (squeeze) hold_req++;
    queue_traffic(n_pkts, fill);
    wait_quiet();
  endtask

  initial begin : stimulus
    logic [CFG_DATA_BITS-1:0] unused_rd;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The register must come out of reset at its documented value.
    check_fill_readback();

    send_idle_pct = 21;
    recv_idle_pct = 74;

    // Directed part at fill level four: a drain on an empty queue, equal timestamps
    // across streams, insertion at the head, at the tail and before an equal maximum
    // timestamp, and the field extremes. The trailing drains empty the queue and then
    // hit it twice more while empty.
    set_fill(4);
    check_fill_readback();
    add_beat(KIND_DRAIN, '0, '0, '0);
    add_beat(KIND_PACKET, 3'd0, 33'd1000, 16'h0000);
    add_beat(KIND_PACKET, 3'd1, 33'd1000, 16'hFFFF);
    add_beat(KIND_PACKET, 3'd0, 33'd500, 16'h0001);
    add_beat(KIND_PACKET, 3'd7, TS_MAX, 16'h8000);
    add_beat(KIND_PACKET, 3'd7, 33'd0, 16'h7FFF);
    add_beat(KIND_PACKET, 3'd1, 33'd999, 16'h1234);
    add_beat(KIND_PACKET, 3'd3, TS_MAX, 16'hAAAA);
    add_beat(KIND_PACKET, 3'd3, 33'd2000, 16'h5555);
    repeat (5) add_beat(KIND_DRAIN, 3'd7, TS_MAX, 16'hFFFF);
    wait_quiet();

    // Fill level zero releases every arrival straight away. The write to the unused
    // register index must leave the fill level alone.
    set_fill(0);
    cfg_access(1'b1, REG_UNUSED, 32'd9, unused_rd);
    check_fill_readback();
    add_beat(KIND_PACKET, 3'd2, 33'd123, 16'h0F0F);
    add_beat(KIND_PACKET, 3'd5, 33'd122, 16'hF0F0);
    add_beat(KIND_PACKET, 3'd2, TS_MAX, 16'h0000);
    wait_quiet();

    // Fill level one behaves the same way, and a drain afterwards finds nothing.
    set_fill(1);
    check_fill_readback();
    add_beat(KIND_PACKET, 3'd6, 33'd77, 16'h0001);
    add_beat(KIND_PACKET, 3'd4, 33'd78, 16'h0002);
    add_beat(KIND_DRAIN, '0, '0, '0);
    wait_quiet();

    // Random phases with a slow receiver. The phase above the depth fills the queue
    // and pushes arrivals into overflow before draining.
    run_phase(1, 20, 1'b0);
    run_phase(DEPTH, 72, 1'b0);
    run_phase(127, 76, 1'b0);
    run_phase(17, 24, 1'b0);

    // Random phases with a slow sender, including the long receiver stall.
    send_idle_pct = 74;
    recv_idle_pct = 21;
    run_phase(0, 20, 1'b0);
    run_phase($urandom_range(2, DEPTH - 1), 30, 1'b0);
    run_phase(8, 40, 1'b1);

    // Back-to-back traffic on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(FILL_RESET, 30, 1'b0);
    run_phase($urandom_range(2, DEPTH - 1), 30, 1'b0);
    run_phase(DEPTH, 10, 1'b0);

    if (release_q.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time, release_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("** timestamp_reorder_queue_top: PASSED **");
    end else begin
      $display("** timestamp_reorder_queue_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== timestamp_reorder_queue_top.f =====
rtl/trq_pkg.sv
rtl/trq_store.sv
rtl/timestamp_reorder_queue_top.sv
tb/tb_timestamp_reorder_queue_top.sv
